// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the sensor frame decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/sfcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame decoder package
// Types, constants and the CRC-8 byte update shared by the decoder files.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    // Result codes reported with each frame.
    typedef enum logic [1:0] {
        RC_OK         = 2'd0,
        RC_FIRST_CRC  = 2'd1,
        RC_SECOND_CRC = 2'd2
    } result_code_t;

    // Byte positions within a frame.
    localparam logic [2:0] POS_WORD0_HI = 3'd0;
    localparam logic [2:0] POS_WORD0_LO = 3'd1;
    localparam logic [2:0] POS_CRC0     = 3'd2;
    localparam logic [2:0] POS_WORD1_HI = 3'd3;
    localparam logic [2:0] POS_WORD1_LO = 3'd4;
    localparam logic [2:0] POS_CRC1     = 3'd5;
    localparam logic [2:0] POS_DONE     = 3'd7;

    // CRC-8 parameters.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Conversion scale factors.
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;

    // Frame kind register values.
    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Completed frame handed from the framer to the conversion stage.
    typedef struct packed {
        logic         is_status;
        result_code_t code;
        logic [15:0]  word0;
        logic [15:0]  word1;
    } frame_event_t;

    // One byte of MSB-first CRC-8 without reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/sfcd_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel carrying one received frame byte per transfer.
// ----------------------------------------------------------------------------
interface sfcd_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);

endinterface

`default_nettype wire

// ===== src/sfcd_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one decoded frame result per transfer.
// ----------------------------------------------------------------------------
interface sfcd_result_if;

    logic               valid;
    logic               ready;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [15:0]        status_word;
    logic [1:0]         result_code;

    modport source (
        output valid, output temperature_centi, output humidity_centi,
        output status_word, output result_code, input ready
    );
    modport sink (
        input valid, input temperature_centi, input humidity_centi,
        input status_word, input result_code, output ready
    );

endinterface

`default_nettype wire

// ===== src/sfcd_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Frame tracker
// Follows the byte position, runs the CRC-8, holds the received words and
// registers one frame event when the last byte of a frame arrives.
// ----------------------------------------------------------------------------
module sfcd_framer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 write_enable,
    input  logic                 write_data,
    sfcd_byte_if.sink            bytes,
    output logic                 ev_valid,
    output sfcd_pkg::frame_event_t ev,
    input  logic                 ev_ready
);
    import sfcd_pkg::*;

    logic         kind_reg;
    logic [2:0]   pos_reg, pos_next;
    logic [7:0]   crc_reg, crc_next;
    logic         first_ok_reg, first_ok_next;
    logic [15:0]  word0_reg, word0_next;
    logic [15:0]  word1_reg, word1_next;
    logic         ev_valid_reg, ev_valid_next;
    frame_event_t ev_reg, ev_next;

    logic         accept;
    logic         emit;
    logic [2:0]   pos_eff;
    logic [7:0]   crc_eff;
    logic [7:0]   crc_upd;
    logic         crc_match;

    // A byte is taken when the event register is free or being drained.
    assign bytes.ready = !ev_valid_reg || ev_ready;
    assign accept      = bytes.valid && bytes.ready;
    assign ev_valid    = ev_valid_reg;
    assign ev          = ev_reg;

    // Frame start restarts the position and the CRC.
    assign pos_eff   = bytes.frame_start ? POS_WORD0_HI : pos_reg;
    assign crc_eff   = bytes.frame_start ? CRC_INIT : crc_reg;
    assign crc_upd   = crc8_byte((pos_eff == POS_WORD1_HI) ? CRC_INIT : crc_eff, bytes.rx_byte);
    assign crc_match = (crc_eff == bytes.rx_byte);

    // Position, CRC, word capture and event generation.
    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        first_ok_next = first_ok_reg;
        word0_next    = word0_reg;
        word1_next    = word1_reg;
        emit          = 1'b0;
        ev_next       = ev_reg;
        if (accept)
        begin
            pos_next = pos_eff;
            crc_next = crc_eff;
            unique case (pos_eff)
                POS_WORD0_HI:
                begin
                    crc_next   = crc_upd;
                    word0_next = {bytes.rx_byte, 8'h00};
                    pos_next   = POS_WORD0_LO;
                end
                POS_WORD0_LO:
                begin
                    crc_next   = crc_upd;
                    word0_next = {word0_reg[15:8], bytes.rx_byte};
                    pos_next   = POS_CRC0;
                end
                POS_CRC0:
                begin
                    first_ok_next = crc_match;
                    if (kind_reg == KIND_STATUS)
                    begin
                        pos_next          = POS_DONE;
                        emit              = 1'b1;
                        ev_next.is_status = 1'b1;
                        ev_next.code      = crc_match ? RC_OK : RC_FIRST_CRC;
                        ev_next.word0     = word0_reg;
                        ev_next.word1     = word1_reg;
                    end
                    else
                    begin
                        pos_next = POS_WORD1_HI;
                    end
                end
                POS_WORD1_HI:
                begin
                    crc_next   = crc_upd;
                    word1_next = {bytes.rx_byte, 8'h00};
                    pos_next   = POS_WORD1_LO;
                end
                POS_WORD1_LO:
                begin
                    crc_next   = crc_upd;
                    word1_next = {word1_reg[15:8], bytes.rx_byte};
                    pos_next   = POS_CRC1;
                end
                POS_CRC1:
                begin
                    pos_next          = POS_DONE;
                    emit              = 1'b1;
                    ev_next.is_status = 1'b0;
                    ev_next.word0     = word0_reg;
                    ev_next.word1     = word1_reg;
                    if (!first_ok_reg)
                    begin
                        ev_next.code = RC_FIRST_CRC;
                    end
                    else if (!crc_match)
                    begin
                        ev_next.code = RC_SECOND_CRC;
                    end
                    else
                    begin
                        ev_next.code = RC_OK;
                    end
                end
                default:
                begin
                    // Complete frame: bytes are dropped until the next start.
                    pos_next = pos_eff;
                end
            endcase
        end
    end

    // The event register fills on a frame end and drains on a downstream transfer.
    always_comb
    begin
        ev_valid_next = ev_valid_reg;
        if (ev_ready)
        begin
            ev_valid_next = 1'b0;
        end
        if (emit)
        begin
            ev_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_MEASURE;
            pos_reg      <= POS_WORD0_HI;
            crc_reg      <= CRC_INIT;
            first_ok_reg <= 1'b0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            if (write_enable)
            begin
                kind_reg <= write_data;
            end
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            first_ok_reg <= first_ok_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        word0_reg <= word0_next;
        word1_reg <= word1_next;
        if (emit)
        begin
            ev_reg <= ev_next;
        end
    end

    // Position six is never reached.
    `ASSERT_SAME(a_pos_legal, clk, rst_n, 1'b1, pos_reg != 3'd6)
    // Each event closes the frame.
    `ASSERT_NEXT(a_emit_done, clk, rst_n, emit, pos_reg == POS_DONE && ev_valid_reg)
    // Events come only from a CRC byte position.
    `ASSERT_SAME(a_emit_pos, clk, rst_n, emit, pos_eff == POS_CRC0 || pos_eff == POS_CRC1)

endmodule

`default_nettype wire

// ===== src/sfcd_convert.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Result conversion
// Scales the raw words to centidegrees and centipercent and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module sfcd_convert (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ev_valid,
    input  sfcd_pkg::frame_event_t ev,
    output logic                   ev_ready,
    sfcd_result_if.source          results
);
    import sfcd_pkg::*;

    logic               out_valid_reg, out_valid_next;
    logic signed [14:0] temp_reg, temp_next;
    logic [13:0]        hum_reg, hum_next;
    logic [15:0]        status_reg, status_next;
    logic [1:0]         code_reg, code_next;

    logic               advance;
    logic               meas_ok;
    logic [30:0]        temp_prod, temp_adj;
    logic [29:0]        hum_prod, hum_adj;
    logic [14:0]        temp_q;
    logic [13:0]        hum_q;
    logic [15:0]        temp_diff;

    assign advance  = !out_valid_reg || results.ready;
    assign ev_ready = advance;

    // Divide by 65535 as (y + (y >> 16)) >> 16 with y = x + 1, exact for
    // quotients below 65536.
    assign temp_prod = 31'(ev.word0) * 31'(TEMP_SPAN) + 31'd1;
    assign temp_adj  = temp_prod + 31'(temp_prod[30:16]);
    assign temp_q    = temp_adj[30:16];
    assign hum_prod  = 30'(ev.word1) * 30'(HUM_SPAN) + 30'd1;
    assign hum_adj   = hum_prod + 30'(hum_prod[29:16]);
    assign hum_q     = hum_adj[29:16];
    assign temp_diff = {1'b0, temp_q} - TEMP_OFFSET;

    // Field selection by frame kind and result code.
    assign meas_ok     = !ev.is_status && (ev.code == RC_OK);
    assign temp_next   = meas_ok ? signed'(temp_diff[14:0]) : 15'sd0;
    assign hum_next    = meas_ok ? hum_q : 14'd0;
    assign status_next = (ev.is_status && (ev.code == RC_OK)) ? ev.word0 : 16'd0;
    assign code_next   = ev.code;

    assign out_valid_next = (ev_valid && advance) || (out_valid_reg && !results.ready);

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload loads on each transfer from the framer.
    always_ff @(posedge clk)
    begin
        if (ev_valid && advance)
        begin
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
            status_reg <= status_next;
            code_reg   <= code_next;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.temperature_centi = temp_reg;
    assign results.humidity_centi    = hum_reg;
    assign results.status_word       = status_reg;
    assign results.result_code       = code_reg;

    // A failed frame reports no readings.
    `ASSERT_SAME(a_err_zero, clk, rst_n, out_valid_reg && code_reg != RC_OK,
        temp_reg == 15'sd0 && hum_reg == 14'd0 && status_reg == 16'd0)
    // Humidity stays within full scale.
    `ASSERT_SAME(a_hum_range, clk, rst_n, out_valid_reg, hum_reg <= HUM_SPAN)
    // A pending event is not lost while the output stalls.
    `ASSERT_SAME(a_stall_hold, clk, rst_n, ev_valid && !advance, out_valid_reg)

endmodule

`default_nettype wire

// ===== src/sensor_frame_crc_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame CRC decode
// Checks and decodes measurement and status frames from a humidity and
// temperature sensor, one byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the event register is
// free or being drained. Each data byte updates the CRC-8 (polynomial
// 0x31, init 0xFF) and every byte the frame position; on the last byte of
// a frame the decoded event is registered, then scaled by 16x15 and 16x14
// multiplies and reciprocal correction into the output register. The event
// register and the output register together let bytes keep flowing while a
// result waits to be taken. frame_kind is written through write_enable and
// write_data and is sampled at the first CRC byte of each frame. There is
// no clearing pass after reset.
module sensor_frame_crc_decode (
    input  logic          clk,
    input  logic          rst_n,
    sfcd_byte_if.sink     bytes,
    sfcd_result_if.source results,
    input  logic          write_enable,
    input  logic          write_data
);
    import sfcd_pkg::*;

    logic         ev_valid;
    logic         ev_ready;
    frame_event_t ev;

    // Byte tracking and CRC check.
    sfcd_framer u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_data   (write_data),
        .bytes        (bytes),
        .ev_valid     (ev_valid),
        .ev           (ev),
        .ev_ready     (ev_ready)
    );

    // Scaling and output register.
    sfcd_convert u_convert (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (ev_valid),
        .ev       (ev),
        .ev_ready (ev_ready),
        .results  (results)
    );

endmodule

`default_nettype wire
